>>> rtl/pva_pkg.sv
package pva_pkg;

	// command codes on the input tuser bit
	localparam logic CMD_ON  = 1'b0;
	localparam logic CMD_OFF = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_START,
		ACT_RELEASE
	} act_t;

	typedef enum logic [1:0] {
		CH_SAME,
		CH_IDLE,
		CH_STEAL
	} choice_t;

	// one result item
	typedef struct packed {
		act_t        action;
		logic [2:0]  voice;
		choice_t     choice;
		logic [6:0]  vel;
	} res_t;

	// microcode step address
	typedef logic [2:0] step_t;

	localparam step_t S_WAIT   = 3'd0;
	localparam step_t S_SCAN   = 3'd1;
	localparam step_t S_SDRAIN = 3'd2;
	localparam step_t S_DECIDE = 3'd3;
	localparam step_t S_AGE    = 3'd4;
	localparam step_t S_ADRAIN = 3'd5;
	localparam step_t S_EMIT   = 3'd6;

	// jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_FIRE,
		C_CNT_LAST,
		C_SKIP,
		C_OUT_FREE
	} cond_sel_t;

	typedef struct packed {
		logic      accept;
		logic      rd_en;
		logic      age_mode;
		logic      cnt_clr;
		logic      decide;
		logic      emit;
		cond_sel_t cond;
		step_t     tgt_t;
		step_t     tgt_f;
	} ctrl_t;

	// condition inputs seen by the sequencer
	typedef struct packed {
		logic in_fire;
		logic cnt_last;
		logic skip;
		logic out_free;
	} cond_t;

	// datapath status back to the top
	typedef struct packed {
		logic cnt_last;
		logic skip;
	} stat_t;

	function automatic ctrl_t rom(input step_t s);
		ctrl_t w;
		w = '0;
		w.cond = C_ALWAYS;
		w.tgt_t = S_WAIT;
		w.tgt_f = S_WAIT;
		unique case (s)
			S_WAIT: begin
				w.accept = 1'b1;
				w.cnt_clr = 1'b1;
				w.cond = C_IN_FIRE;
				w.tgt_t = S_SCAN;
				w.tgt_f = S_WAIT;
			end
			S_SCAN: begin
				w.rd_en = 1'b1;
				w.cond = C_CNT_LAST;
				w.tgt_t = S_SDRAIN;
				w.tgt_f = S_SCAN;
			end
			S_SDRAIN: begin
				w.tgt_t = S_DECIDE;
			end
			S_DECIDE: begin
				w.decide = 1'b1;
				w.cnt_clr = 1'b1;
				w.cond = C_SKIP;
				w.tgt_t = S_EMIT;
				w.tgt_f = S_AGE;
			end
			S_AGE: begin
				w.rd_en = 1'b1;
				w.age_mode = 1'b1;
				w.cond = C_CNT_LAST;
				w.tgt_t = S_ADRAIN;
				w.tgt_f = S_AGE;
			end
			S_ADRAIN: begin
				w.tgt_t = S_EMIT;
			end
			S_EMIT: begin
				w.emit = 1'b1;
				w.cond = C_OUT_FREE;
				w.tgt_t = S_WAIT;
				w.tgt_f = S_EMIT;
			end
			default: begin
				w.tgt_t = S_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/pva_seq.sv
module pva_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  pva_pkg::cond_t cond,
	output pva_pkg::ctrl_t ctrl
);
	import pva_pkg::*;

	step_t pc_q;
	step_t pc_d;
	logic  taken;

	assign ctrl = rom(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:   taken = 1'b1;
			C_IN_FIRE:  taken = cond.in_fire;
			C_CNT_LAST: taken = cond.cnt_last;
			C_SKIP:     taken = cond.skip;
			C_OUT_FREE: taken = cond.out_free;
			default:    taken = 1'b1;
		endcase
		pc_d = taken ? ctrl.tgt_t : ctrl.tgt_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

>>> rtl/pva_datapath.sv
module pva_datapath #(
	parameter int VOICES   = 8,
	parameter int AGE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pva_pkg::ctrl_t ctrl,
	input  logic           start,
	input  logic           cmd,
	input  logic [6:0]     note,
	input  logic [6:0]     velocity,
	input  logic [7:0]     envelope_active,
	input  logic           steal,
	output pva_pkg::stat_t stat,
	output pva_pkg::res_t  res
);
	import pva_pkg::*;

	localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int EW    = 7 + AGE_BITS + 1;

	// voice record: {note, age, idle}
	logic [EW-1:0]       mem_q [VOICES];
	logic [VOICES-1:0]   vld_q;

	logic [IDX_W-1:0]    cnt_q;
	logic                pend_s1;
	logic                age_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [EW-1:0]       rd_data_s1;
	logic                rd_vld_s1;

	logic                cmd_q;
	logic [6:0]          note_q;
	logic [6:0]          vel_q;
	logic [7:0]          env_q;

	logic                match_f_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                idle_f_q;
	logic [IDX_W-1:0]    idle_idx_q;
	logic                seen_q;
	logic [IDX_W-1:0]    old_idx_q;
	logic [AGE_BITS-1:0] old_age_q;

	logic [IDX_W-1:0]    sel_q;
	logic [IDX_W-1:0]    sel_d;
	res_t                res_q;
	res_t                res_d;
	logic                skip;

	// effective view of the entry read last cycle
	logic [6:0]          e_note;
	logic [AGE_BITS-1:0] e_age;
	logic                e_idle;
	logic                e_match;
	logic [7:0]          env_sh;
	logic                env_on;
	logic                is_sel;
	logic                wr_en;
	logic [EW-1:0]       wr_data;
	logic [AGE_BITS-1:0] age_new;

	assign e_note  = rd_data_s1[EW-1:AGE_BITS+1];
	assign e_age   = rd_vld_s1 ? rd_data_s1[AGE_BITS:1] : '0;
	assign e_idle  = !rd_vld_s1 || rd_data_s1[0];
	assign e_match = rd_vld_s1 && (e_note == note_q);

	// voices past the eighth see no envelope
	assign env_sh = env_q >> idx_s1;
	assign env_on = env_sh[0];
	assign is_sel = (idx_s1 == sel_q);

	always_comb begin
		age_new = (e_age == '1) ? e_age : e_age + AGE_BITS'(1);
		if (is_sel) begin
			wr_data = {note_q, {AGE_BITS{1'b0}}, 1'b0};
		end else if (env_on) begin
			wr_data = {e_note, age_new, 1'b0};
		end else begin
			wr_data = {e_note, {AGE_BITS{1'b0}}, 1'b1};
		end
	end

	assign wr_en = pend_s1 && age_s1 && (!e_idle || is_sel);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_s1] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= mem_q[cnt_q];
			rd_vld_s1 <= vld_q[cnt_q];
			idx_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			age_s1 <= 1'b0;
		end else begin
			pend_s1 <= ctrl.rd_en;
			age_s1 <= ctrl.age_mode;
			if (ctrl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctrl.rd_en) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	assign stat.cnt_last = (cnt_q == IDX_W'(VOICES - 1));
	assign stat.skip     = skip;

	// latch the event that the search below works on
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
			note_q <= note;
			vel_q <= velocity;
			env_q <= envelope_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_f_q <= 1'b0;
			idle_f_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (start) begin
			match_f_q <= 1'b0;
			idle_f_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (pend_s1 && !age_s1) begin
			if (e_match && !match_f_q) begin
				match_f_q <= 1'b1;
			end
			if (e_idle && !idle_f_q) begin
				idle_f_q <= 1'b1;
			end
			if (!e_idle) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 && !age_s1) begin
			if (e_match && !match_f_q) begin
				match_idx_q <= idx_s1;
			end
			if (e_idle && !idle_f_q) begin
				idle_idx_q <= idx_s1;
			end
			// strict compare keeps the lowest index on ties
			if (!e_idle && (!seen_q || e_age > old_age_q)) begin
				old_idx_q <= idx_s1;
				old_age_q <= e_age;
			end
		end
	end

	always_comb begin
		res_d = '0;
		skip = 1'b0;
		sel_d = match_idx_q;
		if (cmd_q == CMD_OFF) begin
			skip = 1'b1;
			if (match_f_q) begin
				res_d.action = ACT_RELEASE;
				res_d.voice = 3'(match_idx_q);
			end
		end else if (match_f_q) begin
			res_d.action = ACT_START;
			res_d.voice = 3'(match_idx_q);
			res_d.choice = CH_SAME;
			res_d.vel = vel_q;
		end else if (idle_f_q) begin
			sel_d = idle_idx_q;
			res_d.action = ACT_START;
			res_d.voice = 3'(idle_idx_q);
			res_d.choice = CH_IDLE;
			res_d.vel = vel_q;
		end else if (steal) begin
			sel_d = old_idx_q;
			res_d.action = ACT_START;
			res_d.voice = 3'(old_idx_q);
			res_d.choice = CH_STEAL;
			res_d.vel = vel_q;
		end else begin
			skip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.decide) begin
			res_q <= res_d;
			sel_q <= sel_d;
		end
	end

	assign res = res_q;

endmodule

>>> rtl/poly_voice_allocator_unit.sv
// channel  | signals                            | item
// ---------+------------------------------------+-------------------------------------
// s_axis   | tvalid tready tdata[23:0] tuser[0] | note event: cmd, note, vel, env mask
// m_axis   | tvalid tready tdata[15:0] tuser[1:0] | voice decision: action, voice, ...
// cfg      | cfg_valid cfg_ready cfg_data[0]    | steal_enable write
//
// an event runs through a short microcode program: one scan pass over the voice memory
// (one voice per cycle), a decide step, then a read-modify-write aging pass on note-on;
// a note-off or a rejected note-on skips the aging pass and goes straight to the emit step;
// both passes go through the single read port of the voice memory
// reset is asynchronous; per-voice valid bits make every voice idle at once, no clearing pass
// the result register frees the input side: a new event is taken while a result waits,
// and the program only stalls in its emit step if the previous result is still held
module poly_voice_allocator_unit #(
	parameter int VOICES   = 8,
	parameter int AGE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,        // steal_enable
	// event in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // note[6:0], velocity[13:7], envelope_active[21:14]
	input  logic        s_axis_tuser,    // cmd
	// decision out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,    // voice[2:0], choice[4:3], out_velocity[11:5]
	output logic [1:0]  m_axis_tuser     // action
);
	import pva_pkg::*;

	ctrl_t ctrl;
	cond_t cond;
	stat_t stat;
	res_t  res;

	logic  steal_q;
	logic  in_fire;
	logic  out_free;
	logic  load_out;
	logic  out_vld_q;
	res_t  out_q;

	// steal enable register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steal_q <= 1'b1;
		end else if (cfg_valid) begin
			steal_q <= cfg_data;
		end
	end

	// input side is open only in the wait step of the program
	assign s_axis_tready = ctrl.accept;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// result slot frees when empty or being taken this cycle
	assign out_free = !out_vld_q || m_axis_tready;
	assign load_out = ctrl.emit && out_free;

	assign cond.in_fire  = in_fire;
	assign cond.cnt_last = stat.cnt_last;
	assign cond.skip     = stat.skip;
	assign cond.out_free = out_free;

	pva_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	pva_datapath #(
		.VOICES   (VOICES),
		.AGE_BITS (AGE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.start           (in_fire),
		.cmd             (s_axis_tuser),
		.note            (s_axis_tdata[6:0]),
		.velocity        (s_axis_tdata[13:7]),
		.envelope_active (s_axis_tdata[21:14]),
		.steal           (steal_q),
		.stat            (stat),
		.res             (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'b0, out_q.vel, out_q.choice, out_q.voice};
	assign m_axis_tuser  = out_q.action;

	// an event is never taken in the same cycle its result is emitted
	assert property (@(posedge clk) disable iff (!arst_n) !(in_fire && load_out))
		else $error("accept and emit overlap");

	// only one event in flight: input closes right after an accept
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> !s_axis_tready)
		else $error("input open while an event is in flight");

	// a release carries no choice and no velocity
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q.action == ACT_RELEASE) |->
		(out_q.choice == CH_SAME && out_q.vel == 7'd0))
		else $error("release result has stray fields");

	// a no-voice result is all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q.action == ACT_NONE) |->
		(out_q.voice == 3'd0 && out_q.choice == CH_SAME && out_q.vel == 7'd0))
		else $error("empty result has stray fields");

endmodule

>>> dv/tb_poly_voice_allocator_unit.sv
`timescale 1ns / 1ps

module tb_poly_voice_allocator_unit;
	import pva_pkg::*;

	localparam int VOICES = 8;
	localparam int AGE_BITS = 16;
	localparam logic [AGE_BITS-1:0] AGE_TOP = '1;
	localparam logic [7:0] NO_NOTE = 8'hff;
	localparam int CYCLE_LIMIT = 400_000;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_ITEMS = 122;

	// directed script rows: either an event or a steal_enable write
	typedef enum logic {
		ROW_EVENT,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic       cfg_val;
		logic       cmd;
		logic [6:0] note;
		logic [6:0] vel;
		logic [7:0] env;
		logic       typed;    // expectation written by hand below
		res_t       want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;    // note[6:0], velocity[13:7], envelope_active[21:14]
	logic        s_axis_tuser;    // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;    // voice[2:0], choice[4:3], out_velocity[11:5]
	logic [1:0]  m_axis_tuser;    // action

	// voice bank mirror and the steal setting
	logic [7:0]          slot_note [VOICES];
	logic [AGE_BITS-1:0] slot_age [VOICES];
	logic                slot_idle [VOICES];
	logic                steal_on;

	res_t        decisions_due[$];
	script_row_t rows[$];
	int          mismatches = 0;
	int          gap_hi = 15;
	int          stall_hi = 15;

	poly_voice_allocator_unit #(
		.VOICES(VOICES),
		.AGE_BITS(AGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// works out the decision for one accepted event and moves the voice bank on
	function automatic res_t allocate_voice(input logic cmd, input logic [6:0] note,
			input logic [6:0] vel, input logic [7:0] env);
		res_t                r;
		int                  pick;
		int                  v;
		bit                  seen;
		logic [AGE_BITS-1:0] best_age;
		choice_t             how;
		r = '0;
		pick = -1;
		// first voice still holding the note, idle or not
		for (v = 0; v < VOICES; v++)
			if (pick < 0 && slot_note[v] == {1'b0, note})
				pick = v;
		if (cmd == CMD_OFF) begin
			if (pick >= 0) begin
				r.action = ACT_RELEASE;
				r.voice = pick[2:0];
			end
			return r;
		end
		how = CH_SAME;
		if (pick < 0) begin
			how = CH_IDLE;
			for (v = 0; v < VOICES; v++)
				if (pick < 0 && slot_idle[v])
					pick = v;
		end
		if (pick < 0) begin
			// rejected note-on leaves the bank untouched
			if (!steal_on)
				return r;
			how = CH_STEAL;
			seen = 1'b0;
			best_age = '0;
			pick = 0;
			// strict compare keeps the lowest index among equal ages
			for (v = 0; v < VOICES; v++)
				if (!slot_idle[v] && (!seen || slot_age[v] > best_age)) begin
					seen = 1'b1;
					best_age = slot_age[v];
					pick = v;
				end
		end
		// busy voices age while sounding, go idle once their envelope ended
		for (v = 0; v < VOICES; v++)
			if (!slot_idle[v]) begin
				if (v < 8 && env[v]) begin
					if (slot_age[v] != AGE_TOP)
						slot_age[v] = slot_age[v] + 1'b1;
				end else begin
					slot_idle[v] = 1'b1;
					slot_age[v] = '0;
				end
			end
		slot_note[pick] = {1'b0, note};
		slot_age[pick] = '0;
		slot_idle[pick] = 1'b0;
		r.action = ACT_START;
		r.voice = pick[2:0];
		r.choice = how;
		r.vel = vel;
		return r;
	endfunction

	function automatic script_row_t ev_row(input logic cmd, input logic [6:0] note,
			input logic [6:0] vel, input logic [7:0] env);
		script_row_t r;
		r = '0;
		r.kind = ROW_EVENT;
		r.cmd = cmd;
		r.note = note;
		r.vel = vel;
		r.env = env;
		return r;
	endfunction

	function automatic script_row_t ev_want(input logic cmd, input logic [6:0] note,
			input logic [6:0] vel, input logic [7:0] env, input act_t a,
			input logic [2:0] voice, input choice_t c, input logic [6:0] out_vel);
		script_row_t r;
		r = ev_row(cmd, note, vel, env);
		r.typed = 1'b1;
		r.want.action = a;
		r.want.voice = voice;
		r.want.choice = c;
		r.want.vel = out_vel;
		return r;
	endfunction

	function automatic script_row_t cfg_row(input logic val);
		script_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.cfg_val = val;
		return r;
	endfunction

	// offers one event after a gap, records its decision once taken
	// tvalid stays high when the next event follows with no gap
	task automatic send_event(input logic cmd, input logic [6:0] note, input logic [6:0] vel,
			input logic [7:0] env, input bit use_want, input res_t want, input int gap);
		res_t predicted;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, env, vel, note};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predicted = allocate_voice(cmd, note, vel, env);
		decisions_due.push_back(use_want ? want : predicted);
	endtask

	// sender holds off until every decision is back
	task automatic drain_decisions();
		s_axis_tvalid <= 1'b0;
		while (decisions_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_steal(input logic val);
		drain_decisions();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		steal_on = val;
		cfg_valid <= 1'b0;
	endtask

	// decision sink: random stall per item, check against the oldest expectation
	initial begin : decision_sink
		res_t got;
		res_t want;
		int   stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, stall_hi);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.action = act_t'(m_axis_tuser);
			got.voice = m_axis_tdata[2:0];
			got.choice = choice_t'(m_axis_tdata[4:3]);
			got.vel = m_axis_tdata[11:5];
			if (decisions_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: act %0d voice %0d choice %0d vel %0d",
						got.action, got.voice, got.choice, got.vel);
			end else begin
				want = decisions_due.pop_front();
				if (got.action !== want.action || got.voice !== want.voice ||
						got.choice !== want.choice || got.vel !== want.vel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want act %0d voice %0d choice %0d vel %0d, %s %0d %0d %0d %0d",
							want.action, want.voice, want.choice, want.vel, "got",
							got.action, got.voice, got.choice, got.vel);
				end
			end
		end
	end

	// hard stop on a hung handshake
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		script_row_t r;
		int          i;
		int          k;
		int          p;
		int          base;
		int          sel;
		int          pick_note;
		logic        cmd;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [7:0]  env;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_ON;
		steal_on = 1'b1;
		for (i = 0; i < VOICES; i++) begin
			slot_note[i] = NO_NOTE;
			slot_age[i] = '0;
			slot_idle[i] = 1'b1;
		end

		// directed script: extremes, every command, both steal settings
		rows.push_back(ev_want(CMD_OFF, 7'd0, 7'd0, 8'hff, ACT_NONE, 3'd0, CH_SAME, 7'd0));
		rows.push_back(ev_want(CMD_ON, 7'd0, 7'd127, 8'hff, ACT_START, 3'd0, CH_IDLE, 7'd127));
		rows.push_back(ev_want(CMD_ON, 7'd127, 7'd0, 8'hff, ACT_START, 3'd1, CH_IDLE, 7'd0));
		// no envelope sounding: every busy voice drops, the matched one restarts
		rows.push_back(ev_want(CMD_ON, 7'd0, 7'd5, 8'h00, ACT_START, 3'd0, CH_SAME, 7'd5));
		// an idle voice keeps its note and still answers a note-off
		rows.push_back(ev_want(CMD_OFF, 7'd127, 7'd9, 8'h00, ACT_RELEASE, 3'd1, CH_SAME, 7'd0));
		rows.push_back(ev_want(CMD_ON, 7'd127, 7'd64, 8'hff, ACT_START, 3'd1, CH_SAME, 7'd64));
		for (i = 0; i < 6; i++)
			rows.push_back(ev_row(CMD_ON, 7'(10 + i), 7'(20 * i + 3), 8'hff));
		// bank full, steal the oldest
		rows.push_back(ev_row(CMD_ON, 7'd20, 7'd33, 8'hff));
		rows.push_back(ev_row(CMD_OFF, 7'd20, 7'd0, 8'hff));
		rows.push_back(cfg_row(1'b0));
		// bank full with stealing off: rejected, all fields zero
		rows.push_back(ev_want(CMD_ON, 7'd21, 7'd99, 8'hff, ACT_NONE, 3'd0, CH_SAME, 7'd0));
		rows.push_back(ev_row(CMD_ON, 7'd10, 7'd11, 8'hff));
		rows.push_back(ev_want(CMD_ON, 7'd30, 7'd127, 8'hff, ACT_NONE, 3'd0, CH_SAME, 7'd0));
		rows.push_back(ev_row(CMD_ON, 7'd12, 7'd42, 8'h55));
		rows.push_back(ev_row(CMD_ON, 7'd40, 7'd85, 8'hff));
		rows.push_back(cfg_row(1'b1));
		// note-off with no voice holding it
		rows.push_back(ev_want(CMD_OFF, 7'd99, 7'd127, 8'hff, ACT_NONE, 3'd0, CH_SAME, 7'd0));
		rows.push_back(ev_row(CMD_ON, 7'd127, 7'd127, 8'haa));
		rows.push_back(ev_row(CMD_ON, 7'd77, 7'd1, 8'h80));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < rows.size(); i++) begin
			r = rows[i];
			if (r.kind == ROW_CFG)
				write_steal(r.cfg_val);
			else
				send_event(r.cmd, r.note, r.vel, r.env, r.typed, r.want,
					$urandom_range(0, gap_hi));
		end

		// back to back with no stalls: fill the bank, replay one note so the
		// other voices keep aging, then steal from the full bank
		write_steal(1'b1);
		gap_hi = 0;
		stall_hi = 0;
		send_event(CMD_ON, 7'd100, 7'd50, 8'h00, 1'b0, '0, 0);
		for (i = 1; i < VOICES; i++)
			send_event(CMD_ON, 7'(100 + i), 7'($urandom_range(0, 127)), 8'hff, 1'b0, '0, 0);
		for (k = 0; k < 16; k++)
			send_event(CMD_ON, 7'(100 + VOICES - 1), 7'($urandom_range(0, 127)), 8'hff,
				1'b0, '0, 0);
		for (i = 0; i < 3; i++)
			send_event(CMD_ON, 7'(110 + i), 7'($urandom_range(0, 127)), 8'hff, 1'b0, '0, 0);

		// random phases: notes mostly from a narrow pool so events hit held voices,
		// envelopes mostly sounding so the bank fills and steals or rejects
		for (p = 0; p < RAND_PHASES; p++) begin
			write_steal((p % 2 == 0) ? 1'b1 : 1'b0);
			gap_hi = (p % 3 == 2) ? 0 : 15;
			stall_hi = (p % 4 == 3) ? 0 : 15;
			base = $urandom_range(0, 116);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				cmd = ($urandom_range(0, 9) < 3) ? CMD_OFF : CMD_ON;
				if ($urandom_range(0, 9) == 0)
					pick_note = $urandom_range(0, 127);
				else
					pick_note = base + $urandom_range(0, 11);
				note = pick_note[6:0];
				vel = 7'($urandom_range(0, 127));
				sel = $urandom_range(0, 19);
				if (sel < 11)
					env = 8'hff;
				else if (sel < 16)
					env = ~(8'h01 << $urandom_range(0, 7));
				else if (sel == 16)
					env = 8'h00;
				else
					env = 8'($urandom_range(0, 255));
				send_event(cmd, note, vel, env, 1'b0, '0, $urandom_range(0, gap_hi));
			end
		end

		drain_decisions();
		repeat (2 * VOICES + 8) @(posedge clk);
		if (mismatches == 0 && decisions_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> poly_voice_allocator_unit.f
rtl/pva_pkg.sv
rtl/pva_seq.sv
rtl/pva_datapath.sv
rtl/poly_voice_allocator_unit.sv
dv/tb_poly_voice_allocator_unit.sv
